[rtl/core/yuyv_macropixel_to_rgb24_unit_defines.svh]
// ----------------------------------------------------------------------------
// YUYV to RGB24 unit assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef YUYV_MACROPIXEL_TO_RGB24_UNIT_DEFINES_SVH
`define YUYV_MACROPIXEL_TO_RGB24_UNIT_DEFINES_SVH

// Same-cycle implication
`define YMP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define YMP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> post) \
		else $error(msg);

`endif

[rtl/core/ymp2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB24 package
// Widths, Q10 coefficients and shared types of the YUYV to RGB24 unit.
// ----------------------------------------------------------------------------
package ymp2rgb_pkg;

	localparam int SAMPLE_W = 8;
	localparam int Q_SHIFT  = 10;
	// channel sums stay within +-2^20
	localparam int SUM_W    = 22;
	localparam int CH_W     = SUM_W - Q_SHIFT;

	localparam int IN_W  = 4 * SAMPLE_W;
	localparam int OUT_W = 6 * SAMPLE_W;

	// BT.601 studio-range coefficients, Q10
	localparam logic signed [SUM_W-1:0] COEF_Y  = SUM_W'(1192);
	localparam logic signed [SUM_W-1:0] COEF_UB = SUM_W'(2066);
	localparam logic signed [SUM_W-1:0] COEF_VG = SUM_W'(833);
	localparam logic signed [SUM_W-1:0] COEF_UG = SUM_W'(403);
	localparam logic signed [SUM_W-1:0] COEF_VR = SUM_W'(1634);

	localparam logic signed [SUM_W-1:0] LUMA_OFS   = SUM_W'(16);
	localparam logic signed [SUM_W-1:0] CHROMA_OFS = SUM_W'(128);

	localparam logic [SAMPLE_W-1:0] KNEE_RESET = SAMPLE_W'(250);
	localparam logic [SAMPLE_W-1:0] CH_MAX     = SAMPLE_W'(255);

	// chroma contributions shared by both pixels of a macropixel
	typedef struct packed {
		logic signed [SUM_W-1:0] r_term;
		logic signed [SUM_W-1:0] g_term;
		logic signed [SUM_W-1:0] b_term;
	} chroma_terms_t;

endpackage

[rtl/core/yuyv_macropixel_to_rgb24_unit.sv]
// A request passes the input register and then the result register on its way to m_tdata.
// Throughput: one macropixel per cycle while m_tready stays high.
// The result register frees the input register, so a new request is taken while a
// result waits; s_tready drops only when both registers are full and m_tready is low.
// Reset (arst_n low): both stages empty, clip_knee back to 250.
// ----------------------------------------------------------------------------
// YUYV macropixel to RGB24 unit
// Converts one YUYV macropixel into two RGB888 pixels, BT.601 studio range, Q10.
// ----------------------------------------------------------------------------
module yuyv_macropixel_to_rgb24_unit
	import ymp2rgb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clip_knee_we,
	input  logic [SAMPLE_W-1:0] clip_knee_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	// luma_first, chroma_blue, luma_second, chroma_red (from bit 0 up)
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// red_first, green_first, blue_first, red_second, green_second, blue_second
	output logic [OUT_W-1:0]    m_tdata
);

	logic [SAMPLE_W-1:0] clip_knee_q;
	logic                valid_s1;
	logic                valid_s2;
	logic [IN_W-1:0]     data_s1;
	logic [OUT_W-1:0]    data_s2;
	logic                adv_s2;
	logic                accept;
	chroma_terms_t       terms;
	logic [SAMPLE_W-1:0] r0, g0, b0, r1, g1, b1;

	// pipeline handshake
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign accept   = s_tvalid && s_tready;

	// knee register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_knee_q <= KNEE_RESET;
		end else if (clip_knee_we) begin
			clip_knee_q <= clip_knee_wdata;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_tdata;
		end
	end

	// conversion datapath
	ymp2rgb_chroma u_chroma (
		.chroma_blue (data_s1[2*SAMPLE_W-1:SAMPLE_W]),
		.chroma_red  (data_s1[4*SAMPLE_W-1:3*SAMPLE_W]),
		.terms       (terms)
	);

	ymp2rgb_pixel u_pix_first (
		.luma  (data_s1[SAMPLE_W-1:0]),
		.terms (terms),
		.knee  (clip_knee_q),
		.red   (r0),
		.green (g0),
		.blue  (b0)
	);

	ymp2rgb_pixel u_pix_second (
		.luma  (data_s1[3*SAMPLE_W-1:2*SAMPLE_W]),
		.terms (terms),
		.knee  (clip_knee_q),
		.red   (r1),
		.green (g1),
		.blue  (b1)
	);

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			data_s2 <= {b1, g1, r1, b0, g0, r0};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule

[rtl/core/ymp2rgb_chroma.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB24 chroma terms
// Removes the chroma offsets and forms the U/V products for R, G and B.
// ----------------------------------------------------------------------------
module ymp2rgb_chroma
	import ymp2rgb_pkg::*;
(
	input  logic [SAMPLE_W-1:0] chroma_blue,
	input  logic [SAMPLE_W-1:0] chroma_red,
	output chroma_terms_t       terms
);

	logic signed [SUM_W-1:0] d;
	logic signed [SUM_W-1:0] e;

	// signed chroma differences
	assign d = signed'({{(SUM_W-SAMPLE_W){1'b0}}, chroma_blue}) - CHROMA_OFS;
	assign e = signed'({{(SUM_W-SAMPLE_W){1'b0}}, chroma_red}) - CHROMA_OFS;

	// constant-coefficient products
	assign terms.r_term = COEF_VR * e;
	assign terms.g_term = -(COEF_VG * e) - (COEF_UG * d);
	assign terms.b_term = COEF_UB * d;

endmodule

[rtl/core/ymp2rgb_pixel.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB24 pixel datapath
// Adds the luma term to the chroma terms, floors by 2^10 and clips to 8 bits.
// ----------------------------------------------------------------------------
module ymp2rgb_pixel
	import ymp2rgb_pkg::*;
(
	input  logic [SAMPLE_W-1:0] luma,
	input  chroma_terms_t       terms,
	input  logic [SAMPLE_W-1:0] knee,
	output logic [SAMPLE_W-1:0] red,
	output logic [SAMPLE_W-1:0] green,
	output logic [SAMPLE_W-1:0] blue
);

	// floor then clip: below zero -> 0, above knee -> 255
	function automatic logic [SAMPLE_W-1:0] clip_ch(
		input logic signed [SUM_W-1:0] sum,
		input logic [SAMPLE_W-1:0]     k
	);
		logic signed [CH_W-1:0] v;
		logic signed [CH_W-1:0] k_s;
		logic [SAMPLE_W-1:0]    res;
		v   = signed'(sum[SUM_W-1:Q_SHIFT]);
		k_s = signed'({{(CH_W-SAMPLE_W){1'b0}}, k});
		if (v > k_s) begin
			res = CH_MAX;
		end else if (v < 0) begin
			res = '0;
		end else begin
			res = v[SAMPLE_W-1:0];
		end
		return res;
	endfunction

	logic signed [SUM_W-1:0] c;
	logic signed [SUM_W-1:0] luma_term;

	// luma contribution
	assign c         = signed'({{(SUM_W-SAMPLE_W){1'b0}}, luma}) - LUMA_OFS;
	assign luma_term = COEF_Y * c;

	// channel sums and clipping
	assign red   = clip_ch(luma_term + terms.r_term, knee);
	assign green = clip_ch(luma_term + terms.g_term, knee);
	assign blue  = clip_ch(luma_term + terms.b_term, knee);

endmodule

[rtl/core/ymp2rgb_checker.sv]
// ----------------------------------------------------------------------------
// YUYV to RGB24 port checker
// Watches the stream ports of the unit for stall and latency behavior.
// ----------------------------------------------------------------------------
`include "yuyv_macropixel_to_rgb24_unit_defines.svh"

module ymp2rgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// stalled result keeps its data
	`YMP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

	// input backs up only when the output is full and stalled
	`YMP_ASSERT_NOW(a_ready_low, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

	// an accepted request is followed by m_tvalid high once it could have passed the input and result registers
	`YMP_ASSERT_NEXT(a_latency, s_tvalid && s_tready, ##1 m_tvalid, "result missing after request")

	// an empty output never blocks the input
	`YMP_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input blocked while output empty")

endmodule

bind yuyv_macropixel_to_rgb24_unit ymp2rgb_checker u_ymp2rgb_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUYV macropixel to RGB24 unit testbench
// Streams macropixels through the unit under several clip knee settings,
// predicts both RGB888 pixels of every accepted request in Q10 fixed point,
// and compares each returned result field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
	import ymp2rgb_pkg::*;

	// Q10 conversion gains
	localparam int Y_GAIN = 1192;
	localparam int U_TO_B = 2066;
	localparam int V_TO_G = 833;
	localparam int U_TO_G = 403;
	localparam int V_TO_R = 1634;
	localparam int FRAC_BITS = 10;
	localparam int MAX_PRINTED = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                clip_knee_we = 1'b0;
	logic [SAMPLE_W-1:0] clip_knee_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// luma_first, chroma_blue, luma_second, chroma_red (from bit 0 up)
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// red_first, green_first, blue_first, red_second, green_second, blue_second
	logic [OUT_W-1:0]    m_tdata;

	logic [IN_W-1:0]     macropixel_q[$];
	logic [OUT_W-1:0]    rgb_expect_q[$];
	logic [OUT_W-1:0]    rgb_want;
	logic [SAMPLE_W-1:0] knee_now = KNEE_RESET;
	logic                idle_on = 1'b1;
	logic                sink_block = 1'b0;
	int                  src_gap = 0;
	int                  sink_gap = 0;
	int                  accepted_cnt = 0;
	int                  mismatch_cnt = 0;

	string field_name[6] = '{"red_first", "green_first", "blue_first",
		"red_second", "green_second", "blue_second"};

	yuyv_macropixel_to_rgb24_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.clip_knee_we    (clip_knee_we),
		.clip_knee_wdata (clip_knee_wdata),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata)
	);

	// floor by shift, then clip against the knee
	function automatic logic [7:0] clip_channel(int sum, logic [7:0] knee);
		int v;
		v = sum >>> FRAC_BITS;
		if (v > int'(knee))
			return 8'd255;
		if (v < 0)
			return 8'd0;
		return v[7:0];
	endfunction

	// two RGB888 pixels from one YUYV macropixel
	function automatic logic [OUT_W-1:0] convert_macropixel(logic [IN_W-1:0] px,
			logic [7:0] knee);
		int c0, c1, d, e;
		logic [OUT_W-1:0] rgb;
		c0 = int'(px[7:0]) - 16;
		d  = int'(px[15:8]) - 128;
		c1 = int'(px[23:16]) - 16;
		e  = int'(px[31:24]) - 128;
		rgb[7:0]   = clip_channel(Y_GAIN * c0 + V_TO_R * e, knee);
		rgb[15:8]  = clip_channel(Y_GAIN * c0 - V_TO_G * e - U_TO_G * d, knee);
		rgb[23:16] = clip_channel(Y_GAIN * c0 + U_TO_B * d, knee);
		rgb[31:24] = clip_channel(Y_GAIN * c1 + V_TO_R * e, knee);
		rgb[39:32] = clip_channel(Y_GAIN * c1 - V_TO_G * e - U_TO_G * d, knee);
		rgb[47:40] = clip_channel(Y_GAIN * c1 + U_TO_B * d, knee);
		return rgb;
	endfunction

	function automatic logic [IN_W-1:0] macropixel(logic [7:0] y0, logic [7:0] u,
			logic [7:0] y1, logic [7:0] v);
		return {v, y1, u, y0};
	endfunction

	// corner values are favored over a plain uniform spread
	function automatic logic [7:0] random_sample();
		logic [7:0] corner[8] = '{8'd0, 8'd1, 8'd16, 8'd127, 8'd128, 8'd235, 8'd254, 8'd255};
		if ($urandom_range(0, 3) == 0)
			return corner[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_cnt < MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic push_random(int count);
		@(negedge clk);
		repeat (count)
			macropixel_q.push_back({random_sample(), random_sample(),
				random_sample(), random_sample()});
	endtask

	// wait until every request went out and every result came back
	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		while ((macropixel_q.size() != 0 || s_tvalid || rgb_expect_q.size() != 0)
				&& guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_knee(logic [7:0] value);
		@(posedge clk);
		clip_knee_we    <= 1'b1;
		clip_knee_wdata <= value;
		knee_now        <= value;
		@(posedge clk);
		clip_knee_we    <= 1'b0;
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				rgb_expect_q.push_back(convert_macropixel(s_tdata, knee_now));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (macropixel_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= macropixel_q.pop_front();
					if (idle_on && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 6);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and sink backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (rgb_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					rgb_want = rgb_expect_q.pop_front();
					for (int i = 0; i < 6; i++)
						if (m_tdata[8*i +: 8] !== rgb_want[8*i +: 8])
							report_mismatch($sformatf("%s got %0d want %0d", field_name[i],
								m_tdata[8*i +: 8], rgb_want[8*i +: 8]));
				end
			end
			if (sink_block) begin
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					sink_gap = $urandom_range(1, 6);
			end
		end
	end

	// long sink stall while requests keep coming, fills both stages
	initial begin
		wait (accepted_cnt >= 800);
		@(posedge clk);
		sink_block <= 1'b1;
		repeat (300) @(posedge clk);
		sink_block <= 1'b0;
	end

	// run limit
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// stimulus phases
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset knee: extremes, grey levels, primaries, out-of-range luma
		@(negedge clk);
		macropixel_q.push_back(macropixel(8'd0, 8'd0, 8'd0, 8'd0));
		macropixel_q.push_back(macropixel(8'd255, 8'd255, 8'd255, 8'd255));
		macropixel_q.push_back(macropixel(8'd16, 8'd128, 8'd16, 8'd128));
		macropixel_q.push_back(macropixel(8'd235, 8'd128, 8'd235, 8'd128));
		macropixel_q.push_back(macropixel(8'd0, 8'd128, 8'd255, 8'd128));
		macropixel_q.push_back(macropixel(8'd255, 8'd128, 8'd0, 8'd128));
		macropixel_q.push_back(macropixel(8'd128, 8'd0, 8'd128, 8'd255));
		macropixel_q.push_back(macropixel(8'd128, 8'd255, 8'd128, 8'd0));
		macropixel_q.push_back(macropixel(8'd128, 8'd0, 8'd128, 8'd0));
		macropixel_q.push_back(macropixel(8'd128, 8'd255, 8'd128, 8'd255));
		macropixel_q.push_back(macropixel(8'd235, 8'd16, 8'd16, 8'd240));
		macropixel_q.push_back(macropixel(8'd16, 8'd240, 8'd235, 8'd16));
		macropixel_q.push_back(macropixel(8'd81, 8'd90, 8'd81, 8'd240));
		macropixel_q.push_back(macropixel(8'd145, 8'd54, 8'd145, 8'd34));
		macropixel_q.push_back(macropixel(8'd41, 8'd240, 8'd41, 8'd110));
		macropixel_q.push_back(macropixel(8'd170, 8'd166, 8'd170, 8'd16));
		macropixel_q.push_back(macropixel(8'd210, 8'd16, 8'd210, 8'd146));
		macropixel_q.push_back(macropixel(8'd106, 8'd202, 8'd106, 8'd222));
		macropixel_q.push_back(macropixel(8'd1, 8'd127, 8'd254, 8'd129));
		macropixel_q.push_back(macropixel(8'd17, 8'd128, 8'd17, 8'd128));
		macropixel_q.push_back(macropixel(8'd234, 8'd128, 8'd234, 8'd128));
		push_random(300);
		drain();

		// zero knee: zero stays 0, anything positive saturates
		write_knee(8'd0);
		@(negedge clk);
		macropixel_q.push_back(macropixel(8'd16, 8'd128, 8'd16, 8'd128));
		macropixel_q.push_back(macropixel(8'd17, 8'd128, 8'd17, 8'd128));
		macropixel_q.push_back(macropixel(8'd0, 8'd255, 8'd255, 8'd0));
		push_random(250);
		drain();

		// plain saturation, long sink stall lands in this phase
		write_knee(8'd255);
		push_random(600);
		drain();

		write_knee(8'($urandom_range(1, 254)));
		push_random(300);
		drain();

		write_knee(8'd128);
		push_random(250);
		drain();

		// closing stretch without idling
		write_knee(8'($urandom_range(0, 255)));
		@(posedge clk);
		idle_on <= 1'b0;
		push_random(250);
		drain();

		repeat (8) @(posedge clk);
		if (rgb_expect_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", rgb_expect_q.size()));
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ymp2rgb_pkg.sv
rtl/core/ymp2rgb_chroma.sv
rtl/core/ymp2rgb_pixel.sv
rtl/core/yuyv_macropixel_to_rgb24_unit.sv
rtl/core/ymp2rgb_checker.sv
verif/tb_top.sv
